// File: design/rtp_sequence_number_translator_core_assert.svh
// Assertion macros used by the bound checker rtpsnt_chk.sv.
`ifndef RTP_SEQUENCE_NUMBER_TRANSLATOR_CORE_ASSERT_SVH
`define RTP_SEQUENCE_NUMBER_TRANSLATOR_CORE_ASSERT_SVH

// implication, off while reset is high
`define RTPSNT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtpsnt assertion failed");

// implication, checked in every cycle including reset
`define RTPSNT_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("rtpsnt assertion failed");

`endif

// File: design/rtpsnt_pkg.sv
package rtpsnt_pkg;

   localparam int DEPTH = 1024;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SEQ_W = 16;
   localparam logic [SEQ_W-1:0] DEPTH_SEQ = SEQ_W'(DEPTH);

   localparam logic [2:0] CMD_TRANSLATE = 3'd0;
   localparam logic [2:0] CMD_LOOKUP    = 3'd1;
   localparam logic [2:0] CMD_GENERATE  = 3'd2;
   localparam logic [2:0] CMD_REVERSE   = 3'd3;
   localparam logic [2:0] CMD_RESTART   = 3'd4;

   localparam logic [1:0] KIND_VALID   = 2'd0;
   localparam logic [1:0] KIND_SKIP    = 2'd1;
   localparam logic [1:0] KIND_DISCARD = 2'd2;
   localparam logic [1:0] KIND_GEN     = 2'd3;

   localparam logic CSR_SEQ_BITS    = 1'b0;
   localparam logic CSR_WINDOW_SPAN = 1'b1;

   typedef struct packed {
      logic [SEQ_W-1:0] in_seq;
      logic [SEQ_W-1:0] out_seq;
      logic [1:0]       kind;
   } entry_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_FIRST, OP_STALE, OP_GAP_SETUP, OP_GAP_STEP,
      OP_AHEAD, OP_LOOKUP, OP_INPLACE, OP_MARK, OP_GEN, OP_REVERSE, OP_RESTART,
      OP_ZERO, OP_PUSH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       started;
      logic       stale;
      logic       ahead;
      logic       fwd_kind_valid;
      logic       gap_zero;
      logic       clr_last;
      logic       rsp_busy;
   } dp_sts_type;

   // a before b in modular sequence order
   function automatic logic seq_less(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] mask,
                                     input logic [SEQ_W-1:0] half);
      logic [SEQ_W-1:0] d;
      d = (b - a) & mask;
      return (d != '0) && (d < half);
   endfunction

endpackage

// File: design/rtpsnt_ctrl.sv
module rtpsnt_ctrl
   import rtpsnt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_ctl_type ctl
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_GAP_SETUP, ST_GAP, ST_GAP_FIN, ST_RD1, ST_RD2, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      restart_pend_ff, restart_pend_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         restart_pend_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         restart_pend_ff <= restart_pend_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      restart_pend_in = restart_pend_ff;
      ctl.op          = OP_NONE;
      case (state_ff)
         ST_CLEAR: begin
            ctl.op = OP_CLEAR;
            if (sts.clr_last) begin
               state_in        = restart_pend_ff ? ST_DONE : ST_IDLE;
               restart_pend_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.op   = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            case (sts.cmd)
               CMD_TRANSLATE: begin
                  if (!sts.started) ctl.op = OP_FIRST;
                  else if (sts.stale) ctl.op = OP_STALE;
                  else if (sts.ahead) state_in = ST_GAP_SETUP;
                  else state_in = ST_RD1;
               end
               CMD_LOOKUP, CMD_REVERSE: state_in = ST_RD1;
               CMD_GENERATE: ctl.op = OP_GEN;
               CMD_RESTART: begin
                  if (sts.started) begin
                     ctl.op          = OP_RESTART;
                     state_in        = ST_CLEAR;
                     restart_pend_in = 1'b1;
                  end else begin
                     ctl.op = OP_ZERO;
                  end
               end
               default: ctl.op = OP_ZERO;
            endcase
         end
         ST_GAP_SETUP: begin
            ctl.op   = OP_GAP_SETUP;
            state_in = ST_GAP;
         end
         ST_GAP: begin
            if (sts.gap_zero) state_in = ST_GAP_FIN;
            else ctl.op = OP_GAP_STEP;
         end
         ST_GAP_FIN: begin
            ctl.op   = OP_AHEAD;
            state_in = ST_DONE;
         end
         ST_RD1: begin
            state_in = ST_DONE;
            case (sts.cmd)
               CMD_LOOKUP:  ctl.op = OP_LOOKUP;
               CMD_REVERSE: ctl.op = OP_REVERSE;
               CMD_TRANSLATE: begin
                  if (sts.fwd_kind_valid) state_in = ST_RD2;
                  else ctl.op = OP_INPLACE;
               end
               default: ctl.op = OP_ZERO;
            endcase
         end
         ST_RD2: begin
            ctl.op   = OP_MARK;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               ctl.op   = OP_PUSH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

// File: design/rtpsnt_dp.sv
module rtpsnt_dp
   import rtpsnt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [14:0]      csr_wdata,
   input  logic [2:0]       req_cmd,
   input  logic [SEQ_W-1:0] req_in_seq,
   input  logic [SEQ_W-1:0] req_out_seq,
   input  logic             req_skip_flag,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output entry_type        rsp_entry,
   input  dp_ctl_type       ctl,
   output dp_sts_type       sts
);

   logic [4:0]       seq_bits_ff;
   logic [14:0]      window_ff;
   logic [4:0]       width;
   logic [SEQ_W-1:0] mask, half;

   logic [SEQ_W-1:0] oldest_ff, newest_in_ff, newest_out_ff, gen_off_ff;
   logic             started_ff, restarted_ff;
   logic [2:0]       cmd_ff;
   logic [SEQ_W-1:0] x_ff, y_ff;
   logic             skip_ff;
   logic [SEQ_W-1:0] gap_in_ff, gap_out_ff, fin_out_ff;
   logic [CW-1:0]    gap_cnt_ff;
   logic [AW-1:0]    clr_cnt_ff;
   entry_type        res_ff, rsp_ff;
   logic             rsp_valid_ff;

   entry_type        fwd_mem [DEPTH];
   entry_type        rev_mem [DEPTH];
   entry_type        fwd_rd_ff, rev_rd_ff;
   logic             fwd_we, rev_we;
   logic [AW-1:0]    fwd_wa, rev_wa, rev_ra;
   entry_type        fwd_wd, rev_wd;

   logic [1:0]       kind_x, mark_k;
   logic             fresh;
   logic [SEQ_W-1:0] base, first_o, gen_g, gen_o, low;
   logic [SEQ_W-1:0] gap_first, n_raw, n_eff, n_skip;

   always_comb begin
      if (seq_bits_ff < 5'd10) width = 5'd10;
      else if (seq_bits_ff > 5'd16) width = 5'd16;
      else width = seq_bits_ff;
      mask = 16'hFFFF >> (5'd16 - width);
      half = 16'd1 << (width - 5'd1);
   end

   always_comb begin
      kind_x    = skip_ff ? KIND_SKIP : KIND_VALID;
      mark_k    = skip_ff ? KIND_DISCARD : KIND_VALID;
      fresh     = !(restarted_ff || (gen_off_ff != '0));
      base      = (newest_out_ff + gen_off_ff + 16'd1) & mask;
      first_o   = fresh ? x_ff : base;
      gen_g     = gen_off_ff + 16'd1;
      gen_o     = (gen_g + newest_out_ff) & mask;
      low       = (x_ff - {1'b0, window_ff}) & mask;
      gap_first = (newest_in_ff + 16'd1) & mask;
      n_raw     = (x_ff - gap_first) & mask;
      n_eff     = (n_raw >= half) ? '0 : n_raw;
      // only the last DEPTH numbers of a long gap land in the tables
      n_skip    = (n_eff > DEPTH_SEQ) ? (n_eff - DEPTH_SEQ) : '0;
   end

   assign sts.cmd            = cmd_ff;
   assign sts.started        = started_ff;
   assign sts.stale          = seq_less(x_ff, oldest_ff, mask, half);
   assign sts.ahead          = seq_less(newest_in_ff, x_ff, mask, half);
   assign sts.fwd_kind_valid = (fwd_rd_ff.kind == KIND_VALID);
   assign sts.gap_zero       = (gap_cnt_ff == '0);
   assign sts.clr_last       = (clr_cnt_ff == AW'(DEPTH - 1));
   assign sts.rsp_busy       = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_entry  = rsp_ff;

   // table write ports
   always_comb begin
      fwd_we = 1'b0;
      rev_we = 1'b0;
      fwd_wa = x_ff[AW-1:0];
      rev_wa = x_ff[AW-1:0];
      fwd_wd = '0;
      rev_wd = '0;
      case (ctl.op)
         OP_CLEAR: begin
            fwd_we = 1'b1;
            rev_we = 1'b1;
            fwd_wa = clr_cnt_ff;
            rev_wa = clr_cnt_ff;
         end
         OP_FIRST: begin
            fwd_we = 1'b1;
            rev_we = 1'b1;
            rev_wa = first_o[AW-1:0];
            fwd_wd = '{x_ff, first_o, kind_x};
            rev_wd = '{x_ff, first_o, kind_x};
         end
         OP_GAP_STEP: begin
            fwd_we = 1'b1;
            rev_we = 1'b1;
            fwd_wa = gap_in_ff[AW-1:0];
            rev_wa = gap_out_ff[AW-1:0];
            fwd_wd = '{gap_in_ff, gap_out_ff, KIND_VALID};
            rev_wd = '{gap_in_ff, gap_out_ff, KIND_VALID};
         end
         OP_AHEAD: begin
            fwd_we = 1'b1;
            rev_we = 1'b1;
            rev_wa = fin_out_ff[AW-1:0];
            fwd_wd = '{x_ff, fin_out_ff, kind_x};
            rev_wd = '{x_ff, fin_out_ff, kind_x};
         end
         OP_MARK: begin
            fwd_we = 1'b1;
            rev_we = 1'b1;
            rev_wa = fwd_rd_ff.out_seq[AW-1:0];
            fwd_wd = '{fwd_rd_ff.in_seq, fwd_rd_ff.out_seq, mark_k};
            rev_wd = '{rev_rd_ff.in_seq, rev_rd_ff.out_seq, mark_k};
         end
         OP_GEN: begin
            rev_we = 1'b1;
            rev_wa = gen_o[AW-1:0];
            rev_wd = '{16'd0, gen_o, KIND_GEN};
         end
         default: ;
      endcase
   end

   assign rev_ra = (cmd_ff == CMD_REVERSE) ? y_ff[AW-1:0] : fwd_rd_ff.out_seq[AW-1:0];

   always_ff @(posedge clock) begin
      if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
      fwd_rd_ff <= fwd_mem[x_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rev_we) rev_mem[rev_wa] <= rev_wd;
      rev_rd_ff <= rev_mem[rev_ra];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_bits_ff   <= 5'd16;
         window_ff     <= 15'd500;
         oldest_ff     <= '0;
         newest_in_ff  <= '0;
         newest_out_ff <= '0;
         gen_off_ff    <= '0;
         started_ff    <= 1'b0;
         restarted_ff  <= 1'b0;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_SEQ_BITS) seq_bits_ff <= csr_wdata[4:0];
            else window_ff <= csr_wdata;
         end
         if (ctl.op == OP_PUSH) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (ctl.op)
            OP_CLEAR: clr_cnt_ff <= sts.clr_last ? '0 : clr_cnt_ff + AW'(1);
            OP_FIRST: begin
               if (!skip_ff && (seq_less(newest_out_ff, first_o, mask, half) || fresh))
                  newest_out_ff <= first_o;
               if (!skip_ff) begin
                  newest_in_ff <= x_ff;
                  oldest_ff    <= x_ff;
                  started_ff   <= 1'b1;
                  restarted_ff <= 1'b0;
                  gen_off_ff   <= '0;
               end
            end
            OP_AHEAD: begin
               if (!skip_ff && seq_less(newest_out_ff, fin_out_ff, mask, half))
                  newest_out_ff <= fin_out_ff;
               newest_in_ff <= x_ff;
               if (seq_less(oldest_ff, low, mask, half)) oldest_ff <= low;
               if (!skip_ff) gen_off_ff <= '0;
            end
            OP_INPLACE, OP_MARK: begin
               if (!skip_ff && seq_less(newest_out_ff, fwd_rd_ff.out_seq, mask, half))
                  newest_out_ff <= fwd_rd_ff.out_seq;
            end
            OP_GEN: gen_off_ff <= gen_g;
            OP_RESTART: begin
               started_ff   <= 1'b0;
               restarted_ff <= 1'b1;
               oldest_ff    <= '0;
               newest_in_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // item, gap walk and result payload
   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_LOAD: begin
            cmd_ff  <= req_cmd;
            x_ff    <= req_in_seq & mask;
            y_ff    <= req_out_seq & mask;
            skip_ff <= req_skip_flag;
         end
         OP_GAP_SETUP: begin
            gap_in_ff  <= (gap_first + n_skip) & mask;
            gap_out_ff <= (base + n_skip) & mask;
            gap_cnt_ff <= CW'(n_eff - n_skip);
            fin_out_ff <= (base + n_eff) & mask;
         end
         OP_GAP_STEP: begin
            gap_in_ff  <= (gap_in_ff + 16'd1) & mask;
            gap_out_ff <= (gap_out_ff + 16'd1) & mask;
            gap_cnt_ff <= gap_cnt_ff - CW'(1);
         end
         OP_FIRST:   res_ff <= '{x_ff, first_o, kind_x};
         OP_STALE:   res_ff <= '{x_ff, 16'd0, KIND_SKIP};
         OP_AHEAD:   res_ff <= '{x_ff, fin_out_ff, kind_x};
         OP_LOOKUP:  res_ff <= (fwd_rd_ff.in_seq == x_ff) ? fwd_rd_ff : '{16'd0, 16'd0, KIND_SKIP};
         OP_INPLACE: res_ff <= fwd_rd_ff;
         OP_MARK:    res_ff <= '{fwd_rd_ff.in_seq, fwd_rd_ff.out_seq, mark_k};
         OP_GEN:     res_ff <= '{16'd0, gen_o, KIND_GEN};
         OP_REVERSE: begin
            if ((rev_rd_ff.out_seq != y_ff) ||
                seq_less(rev_rd_ff.in_seq, oldest_ff, mask, half) ||
                seq_less(newest_in_ff, rev_rd_ff.in_seq, mask, half))
               res_ff <= '{16'd0, y_ff, KIND_DISCARD};
            else
               res_ff <= rev_rd_ff;
         end
         OP_RESTART, OP_ZERO: res_ff <= '0;
         OP_PUSH:    rsp_ff <= res_ff;
         default: ;
      endcase
   end

endmodule

// File: design/rtp_sequence_number_translator_core.sv
// Channel | Dir | Ports                  | Contents
// req     | in  | req_tvalid/tready      | tdata: in_seq, out_seq; tuser: cmd, skip_flag
// rsp     | out | rsp_tvalid/tready      | tdata: res_in_seq, res_out_seq; tuser: kind
// csr     | in  | csr_we/addr/wdata      | 0 seq_bits, 1 window_span, no read-back
//
// One item at a time. Generate, restart-when-idle, first and stale translates go from
// ST_DECODE straight to ST_DONE; lookup, reverse and an in-place translate pass
// through ST_RD1, a retranslate that marks its entry also through ST_RD2. A translate
// that jumps ahead passes ST_GAP_SETUP, ST_GAP (one gap entry written per step, up to DEPTH) and ST_GAP_FIN.
// After reset, and after a restart while started, a clearing pass sweeps both
// tables one entry per cycle with req_tready low.
// A stalled rsp holds its result; req is taken again once the result is parked.
module rtp_sequence_number_translator_core
   import rtpsnt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] in_seq, [31:16] out_seq
   input  logic [3:0]  req_tuser,   // [2:0] cmd, [3] skip_flag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] res_in_seq, [31:16] res_out_seq
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [14:0] csr_wdata
);

   dp_ctl_type ctl;
   dp_sts_type sts;
   entry_type  rsp_entry;

   // FSM sequences table reads, gap walk and clearing
   rtpsnt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   // tables, window state and result registers
   rtpsnt_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .req_cmd       (req_tuser[2:0]),
      .req_in_seq    (req_tdata[15:0]),
      .req_out_seq   (req_tdata[31:16]),
      .req_skip_flag (req_tuser[3]),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_entry     (rsp_entry),
      .ctl           (ctl),
      .sts           (sts)
   );

   assign rsp_tdata = {rsp_entry.out_seq, rsp_entry.in_seq};
   assign rsp_tuser = rsp_entry.kind;

endmodule

// File: design/rtpsnt_chk.sv
`include "rtp_sequence_number_translator_core_assert.svh"

module rtpsnt_chk
   import rtpsnt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [3:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_we,
   input logic        csr_addr,
   input logic [14:0] csr_wdata
);

   // clearing pass follows reset
   `RTPSNT_ASSERT_ALWAYS(a_clear_after_reset, clock, $past(reset) && !reset, !req_tready)
   // one item in flight
   `RTPSNT_ASSERT_IMPL(a_one_item, clock, reset, $past(req_tvalid && req_tready), !req_tready)
   // generated entries carry no incoming number
   `RTPSNT_ASSERT_IMPL(a_gen_in_zero, clock, reset, rsp_tvalid && (rsp_tuser == KIND_GEN),
                       rsp_tdata[15:0] == 16'd0)
   // stalled result holds
   `RTPSNT_ASSERT_IMPL(a_rsp_hold, clock, reset, $past(rsp_tvalid && !rsp_tready) && !$past(reset),
                       rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind rtp_sequence_number_translator_core rtpsnt_chk u_rtpsnt_chk (.*);

// File: dv/rtpsnt_checker.sv
module rtpsnt_checker
   import rtpsnt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [3:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [14:0] csr_wdata,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [4:0]  seq_bits_q;
   logic [14:0] span_q;
   entry_type   fwd_tab [DEPTH];
   entry_type   rev_tab [DEPTH];
   logic [15:0] oldest_in, newest_in, newest_out, gen_offset;
   logic        started, restarted;
   entry_type   pending_q [$];

   function automatic int eff_width();
      if (seq_bits_q < 10) return 10;
      if (seq_bits_q > 16) return 16;
      return seq_bits_q;
   endfunction

   function automatic logic [15:0] seq_mask();
      return 16'((32'd1 << eff_width()) - 1);
   endfunction

   function automatic logic [15:0] wrapv(input int v);
      return 16'(v) & seq_mask();
   endfunction

   function automatic logic seq_before(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] d;
      d = (b - a) & seq_mask();
      return (d != 0) && (32'(d) < (32'd1 << (eff_width() - 1)));
   endfunction

   function automatic void store(input logic [15:0] i, input logic [15:0] o,
                                 input logic [1:0] k);
      fwd_tab[i % DEPTH] = '{i, o, k};
      rev_tab[o % DEPTH] = '{i, o, k};
   endfunction

   function automatic void bump_out(input logic skip, input logic [15:0] o,
                                    input logic first);
      if (!skip && (seq_before(newest_out, o) || first)) newest_out = o;
   endfunction

   function automatic void clear_tables();
      for (int i = 0; i < DEPTH; i++) begin
         fwd_tab[i] = '0;
         rev_tab[i] = '0;
      end
   endfunction

   // consecutive outputs for inputs first .. last-1, only the newest DEPTH written
   function automatic logic [15:0] fill_gap(input logic [15:0] first, input logic [15:0] last);
      int base, n, i;
      base = wrapv(int'(newest_out) + int'(gen_offset) + 1);
      n    = (last - first) & seq_mask();
      i    = 0;
      if (n >= (1 << (eff_width() - 1))) n = 0;
      if (n > DEPTH) i = n - DEPTH;
      for (; i < n; i++) store(wrapv(int'(first) + i), wrapv(base + i), KIND_VALID);
      return wrapv(base + n);
   endfunction

   function automatic entry_type translate_item(input logic [2:0] cmd, input logic [15:0] x,
                                                input logic [15:0] y, input logic skip);
      entry_type   e;
      logic [1:0]  k, kk;
      logic [15:0] o, low;
      logic        fresh;
      k = skip ? KIND_SKIP : KIND_VALID;
      e = '0;
      case (cmd)
         CMD_TRANSLATE: begin
            if (!started) begin
               fresh = !(restarted || gen_offset != 0);
               o = fresh ? x : wrapv(int'(newest_out) + int'(gen_offset) + 1);
               store(x, o, k);
               bump_out(skip, o, fresh);
               if (!skip) begin
                  newest_in  = x;
                  oldest_in  = x;
                  started    = 1'b1;
                  restarted  = 1'b0;
                  gen_offset = '0;
               end
               e = '{x, o, k};
            end else if (seq_before(x, oldest_in)) begin
               e = '{x, 16'd0, KIND_SKIP};
            end else if (seq_before(newest_in, x)) begin
               o = fill_gap(wrapv(int'(newest_in) + 1), x);
               bump_out(skip, o, 1'b0);
               store(x, o, k);
               newest_in = x;
               low = wrapv(int'(x) - int'(span_q));
               if (seq_before(oldest_in, low)) oldest_in = low;
               if (!skip) gen_offset = '0;
               e = '{x, o, k};
            end else begin
               // retranslate: slot taken as is, even when its key differs
               e = fwd_tab[x % DEPTH];
               if (e.kind == KIND_VALID) begin
                  kk = skip ? KIND_DISCARD : KIND_VALID;
                  rev_tab[e.out_seq % DEPTH].kind = kk;
                  e.kind = kk;
                  fwd_tab[x % DEPTH] = e;
               end
               bump_out(skip, e.out_seq, 1'b0);
            end
         end
         CMD_LOOKUP: begin
            e = fwd_tab[x % DEPTH];
            if (e.in_seq != x) e = '{16'd0, 16'd0, KIND_SKIP};
         end
         CMD_GENERATE: begin
            gen_offset = gen_offset + 16'd1;
            o = wrapv(int'(gen_offset) + int'(newest_out));
            e = '{16'd0, o, KIND_GEN};
            rev_tab[o % DEPTH] = e;
         end
         CMD_REVERSE: begin
            e = rev_tab[y % DEPTH];
            if (e.out_seq != y || seq_before(e.in_seq, oldest_in) ||
                seq_before(newest_in, e.in_seq))
               e = '{16'd0, y, KIND_DISCARD};
         end
         CMD_RESTART: begin
            if (started) begin
               started   = 1'b0;
               restarted = 1'b1;
               oldest_in = '0;
               newest_in = '0;
               clear_tables();
            end
         end
         default: ;
      endcase
      return e;
   endfunction

   always @(posedge clock) begin
      entry_type got, want;
      if (reset) begin
         seq_bits_q = 5'd16;
         span_q     = 15'd500;
         oldest_in  = '0;
         newest_in  = '0;
         newest_out = '0;
         gen_offset = '0;
         started    = 1'b0;
         restarted  = 1'b0;
         clear_tables();
         pending_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_SEQ_BITS) seq_bits_q = csr_wdata[4:0];
            else span_q = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser};
            if (pending_q.size() == 0) begin
               $display("%0t unexpected result: got %h", $realtime, got);
               fail_count++;
            end else begin
               want = pending_q.pop_front();
               if (got.in_seq != want.in_seq) begin
                  $display("%0t res_in_seq: expected %h actual %h", $realtime,
                           want.in_seq, got.in_seq);
                  fail_count++;
               end
               if (got.out_seq != want.out_seq) begin
                  $display("%0t res_out_seq: expected %h actual %h", $realtime,
                           want.out_seq, got.out_seq);
                  fail_count++;
               end
               if (got.kind != want.kind) begin
                  $display("%0t kind: expected %0d actual %0d", $realtime,
                           want.kind, got.kind);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_q.push_back(translate_item(req_tuser[2:0],
                                               req_tdata[15:0] & seq_mask(),
                                               req_tdata[31:16] & seq_mask(),
                                               req_tuser[3]));
      end
   end

   initial fail_count = 0;

   // always-true property; leftover results are caught by the bench's count check
   final_check: assert property (@(posedge clock) 1'b1);
endmodule

// File: dv/tb_rtp_sequence_number_translator_core.sv
module tb_rtp_sequence_number_translator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import rtpsnt_pkg::*;

   // unused command codes, block answers with all-zero result
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   // cycles without any transfer before the run is declared hung:
   // clearing pass + full gap walk + longest stalls, several times over
   localparam int HANG_LIMIT = 12000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [15:0] in_seq, [31:16] out_seq
   logic [3:0]  req_tuser = '0;    // [2:0] cmd, [3] skip_flag
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [15:0] res_in_seq, [31:16] res_out_seq
   logic [1:0]  rsp_tuser;         // [1:0] kind
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [14:0] csr_wdata = '0;

   int          fail_count;
   int          sent_cnt = 0;
   int          recv_cnt = 0;
   int          quiet_cycles = 0;
   int          ready_hold = 0;
   logic [15:0] last_out = '0;     // most recent res_out_seq, aims reverse commands
   logic [15:0] cursor = '0;       // running incoming number for well-formed streams

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rtp_sequence_number_translator_core dut (.*);

   rtpsnt_checker u_checker (.*);

   // result side: random stalls, short ones mostly, some long, some long open runs
   always @(posedge clock) begin
      int p;
      if (ready_hold == 0) begin
         p = $urandom_range(0, 99);
         if (p < 50) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(1, 8);
         end else if (p < 80) begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(1, 3);
         end else if (p < 95) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(20, 60);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(20, 50);
         end
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   // transfer counts and hang watchdog
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         recv_cnt <= recv_cnt + 1;
         last_out <= rsp_tdata[31:16];
      end
      if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one request transfer, preceded by a random idle gap that may be empty
   task automatic send(input logic [2:0] cmd, input logic [15:0] in_seq,
                       input logic [15:0] out_seq, input logic skip);
      int p, gap;
      p = $urandom_range(0, 99);
      gap = (p < 40) ? 0 : (p < 85) ? $urandom_range(1, 3) :
            (p < 95) ? $urandom_range(4, 10) : $urandom_range(20, 50);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {out_seq, in_seq};
      req_tuser  <= {skip, cmd};
      do @(posedge clock); while (!req_tready);
      sent_cnt++;
   endtask

   // wait until every result is back and the block can take a request again
   task automatic settle();
      req_tvalid <= 1'b0;
      while (recv_cnt != sent_cnt) @(posedge clock);
      repeat (10) @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // both registers, back to back; write enable stays high across both writes
   task automatic configure(input logic [4:0] width, input logic [14:0] span);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_SEQ_BITS;
      csr_wdata <= 15'(width);
      @(posedge clock);
      csr_addr  <= CSR_WINDOW_SPAN;
      csr_wdata <= span;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_item();
      int          p, q;
      logic [15:0] junk;
      p = $urandom_range(0, 99);
      junk = 16'($urandom);
      if (p < 55) begin
         q = $urandom_range(0, 99);
         if (q < 80)      cursor = cursor + 16'd1;
         else if (q < 90) cursor = cursor + 16'($urandom_range(2, 20));
         else if (q < 96) cursor = cursor - 16'($urandom_range(0, 30));
         else if (q < 99) cursor = cursor + 16'($urandom_range(100, 3000));
         else             cursor = 16'($urandom);
         send(CMD_TRANSLATE, cursor, junk, $urandom_range(0, 99) < 15);
      end else if (p < 65) begin
         send(CMD_LOOKUP,
              ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : cursor - 16'($urandom_range(0, 40)),
              junk, 1'($urandom_range(0, 1)));
      end else if (p < 73) begin
         send(CMD_GENERATE, 16'($urandom), junk, 1'($urandom_range(0, 1)));
      end else if (p < 88) begin
         send(CMD_REVERSE, 16'($urandom),
              ($urandom_range(0, 4) == 0) ? junk : last_out - 16'($urandom_range(0, 40)),
              1'($urandom_range(0, 1)));
      end else if (p < 91) begin
         send(CMD_RESTART, 16'($urandom), junk, 1'($urandom_range(0, 1)));
      end else if (p < 94) begin
         send(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 16'($urandom), junk,
              1'($urandom_range(0, 1)));
      end else begin
         send(CMD_TRANSLATE, 16'($urandom), junk, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [4:0]  widths [5] = '{5'd16, 5'd10, 5'd31, 5'd3, 5'd12};
      logic [14:0] spans  [5];
      spans = '{15'd500, 15'd0, 15'd32767, 15'd20, 15'($urandom_range(30, 2000))};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (!req_tready) @(posedge clock);   // clearing pass after reset

      // directed: default width 16, window 500
      send(CMD_REVERSE, 16'd0, 16'd0, 1'b0);        // reverse before any packet
      send(CMD_TRANSLATE, 16'd100, 16'd0, 1'b1);    // skipped first packet
      send(CMD_TRANSLATE, 16'd100, 16'd0, 1'b0);    // first forwarded packet
      send(CMD_TRANSLATE, 16'd101, 16'd0, 1'b0);
      send(CMD_TRANSLATE, 16'd105, 16'd0, 1'b0);    // short gap
      send(CMD_TRANSLATE, 16'd103, 16'd0, 1'b1);    // skip on filled entry -> discard
      send(CMD_TRANSLATE, 16'd103, 16'd0, 1'b0);
      send(CMD_LOOKUP, 16'd103, 16'hFFFF, 1'b0);
      send(CMD_LOOKUP, 16'd999, 16'd0, 1'b0);       // lookup miss
      send(CMD_GENERATE, 16'd0, 16'd0, 1'b0);
      send(CMD_GENERATE, 16'hFFFF, 16'hFFFF, 1'b1);
      send(CMD_TRANSLATE, 16'd106, 16'd0, 1'b0);
      send(CMD_REVERSE, 16'd0, 16'd104, 1'b0);
      send(CMD_REVERSE, 16'd0, 16'd60000, 1'b0);    // reverse miss
      send(CMD_TRANSLATE, 16'd50, 16'd0, 1'b0);     // older than window
      send(CMD_TRANSLATE, 16'd3100, 16'd0, 1'b0);   // gap longer than the tables
      send(CMD_TRANSLATE, 16'd1124, 16'd0, 1'b0);   // older than window after long gap
      send(CMD_REVERSE, 16'd0, 16'd120, 1'b0);      // mapped but outside window now
      send(CMD_TRANSLATE, 16'hFFFF, 16'hFFFF, 1'b1);
      send(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 1'b1);
      send(CMD_SPARE_HI, 16'd0, 16'd0, 1'b0);
      send(CMD_RESTART, 16'd0, 16'd0, 1'b0);
      send(CMD_RESTART, 16'd0, 16'd0, 1'b0);        // restart while not started
      send(CMD_GENERATE, 16'd0, 16'd0, 1'b0);
      send(CMD_TRANSLATE, 16'd7, 16'd0, 1'b0);      // first packet after restart
      settle();

      // random phases across widths and windows, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         configure(widths[ph], spans[ph]);
         cursor = 16'($urandom);
         // wide numbers wrap at narrow widths
         send(CMD_TRANSLATE, 16'hFFFF, 16'hFFFF, 1'b0);
         for (int n = 0; n < 80; n++) random_item();
         settle();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && recv_cnt == sent_cnt)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

// File: rtp_sequence_number_translator_core.f
+incdir+design
design/rtpsnt_pkg.sv
design/rtpsnt_ctrl.sv
design/rtpsnt_dp.sv
design/rtp_sequence_number_translator_core.sv
design/rtpsnt_chk.sv
dv/rtpsnt_checker.sv
dv/tb_rtp_sequence_number_translator_core.sv
